// ----- hw/rtl/cfs_pkg.sv -----
package cfs_pkg;

  // Ring geometry.
  localparam int DEPTH  = 128;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Field widths of the stream items.
  localparam int FUNC_W   = 2;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 7;
  localparam int OUT_W    = ((DATA_W + SLOT_W + 7) / 8) * 8;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH   = 2'd0,
    FUNC_POP    = 2'd1,
    FUNC_SEARCH = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_NOTFOUND  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP_WAIT,
    S_SEARCH
  } state_t;

  // Source of the result word.
  typedef enum logic [1:0] {
    VAL_ZERO,
    VAL_ONES,
    VAL_RDATA
  } val_sel_t;

  // Controller to datapath.
  typedef struct packed {
    logic     do_push;
    logic     do_pop;
    logic     start_scan;
    logic     scan;
    logic     load;
    status_t  ld_status;
    val_sel_t ld_val;
    logic     ld_slot;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic hit;
    logic scan_end;
    logic out_busy;
  } sts_t;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    next_slot = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

// ----- hw/rtl/cfs_ctrl.sv -----
module cfs_ctrl
  import cfs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [FUNC_W-1:0] in_func,
  output logic              in_ready,
  input  sts_t              sts,
  output cmd_t              cmd
);

  state_t state, state_next;
  logic   accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE) && !sts.out_busy;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.ld_status = ST_DONE;
    cmd.ld_val    = VAL_ZERO;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (func_t'(in_func))
            FUNC_PUSH: begin
              cmd.load = 1'b1;
              if (sts.full) begin
                cmd.ld_status = ST_OVERFLOW;
              end else begin
                cmd.do_push = 1'b1;
              end
            end
            FUNC_POP: begin
              if (sts.empty) begin
                cmd.load      = 1'b1;
                cmd.ld_status = ST_UNDERFLOW;
                cmd.ld_val    = VAL_ONES;
              end else begin
                cmd.do_pop = 1'b1;
                state_next = S_POP_WAIT;
              end
            end
            FUNC_SEARCH: begin
              if (sts.empty) begin
                cmd.load      = 1'b1;
                cmd.ld_status = ST_NOTFOUND;
              end else begin
                cmd.start_scan = 1'b1;
                state_next     = S_SEARCH;
              end
            end
            FUNC_NOP: begin
              cmd.load = 1'b1;
            end
            default: begin
              cmd.load = 1'b1;
            end
          endcase
        end
      end
      S_POP_WAIT: begin
        cmd.load   = 1'b1;
        cmd.ld_val = VAL_RDATA;
        state_next = S_IDLE;
      end
      S_SEARCH: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          cmd.load    = 1'b1;
          cmd.ld_slot = 1'b1;
          state_next  = S_IDLE;
        end else if (sts.scan_end) begin
          cmd.load      = 1'b1;
          cmd.ld_status = ST_NOTFOUND;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/cfs_dp.sv -----
module cfs_dp
  import cfs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [DATA_W-1:0]   in_data,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [DATA_W-1:0]   out_value,
  output logic [SLOT_W-1:0]   out_slot
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data;
  logic [PTR_W-1:0]  rd_addr;
  logic [PTR_W-1:0]  rd_slot;
  logic              rd_vld;

  logic [PTR_W-1:0]  head;
  logic [PTR_W-1:0]  tail;
  logic [CNT_W-1:0]  count;

  logic [PTR_W-1:0]  scan_addr;
  logic [CNT_W-1:0]  scan_left;
  logic [DATA_W-1:0] key;
  logic              issue;
  logic              hit;

  assign hit   = rd_vld && (rd_data == key);
  assign issue = cmd.scan && (scan_left != '0) && !hit;
  assign rd_addr = cmd.do_pop ? head : scan_addr;

  always_ff @(posedge clk) begin
    if (cmd.do_push) begin
      mem[tail] <= in_data;
    end
    rd_data <= mem[rd_addr];
    rd_slot <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      rd_vld    <= 1'b0;
      scan_left <= '0;
      out_valid <= 1'b0;
    end else begin
      rd_vld <= issue;
      if (cmd.do_push) begin
        tail  <= next_slot(tail);
        count <= count + 1'b1;
      end
      if (cmd.do_pop) begin
        head  <= next_slot(head);
        count <= count - 1'b1;
      end
      if (cmd.start_scan) begin
        scan_left <= count;
      end else if (issue) begin
        scan_left <= scan_left - 1'b1;
      end
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_scan) begin
      scan_addr <= head;
      key       <= in_data;
    end else if (issue) begin
      scan_addr <= next_slot(scan_addr);
    end
    if (cmd.load) begin
      out_status <= cmd.ld_status;
      unique case (cmd.ld_val)
        VAL_ZERO:  out_value <= '0;
        VAL_ONES:  out_value <= '1;
        VAL_RDATA: out_value <= rd_data;
        default:   out_value <= '0;
      endcase
      out_slot <= cmd.ld_slot ? SLOT_W'(rd_slot) : '0;
    end
  end

  always_comb begin
    sts.full     = (count == CNT_W'(DEPTH));
    sts.empty    = (count == '0);
    sts.hit      = hit;
    sts.scan_end = rd_vld && !hit && (scan_left == '0);
    sts.out_busy = out_valid;
  end

endmodule

// ----- hw/rtl/circular_fifo_with_search_top.sv -----
// Channel  | Direction | tdata (low bit up)               | tuser        | Role
// s_axis   | in        | data[31:0]                       | func[1:0]    | push, pop, search
// m_axis   | out       | value[31:0], slot[38:32], 0 [39] | status[1:0]  | one result per item
//
// A push, a dropped push, an underflow pop, an empty search and the unused
// opcode each load their result in the cycle after the input transfer. A pop
// reads the storage RAM through its registered read port and loads the result
// in the S_POP_WAIT state. A search walks the occupied entries one per cycle,
// oldest first, and stops at the first match or after the newest entry, so it
// looks at no more entries than the occupancy. Reset clears head, tail,
// occupancy and the result valid flag; storage contents are not cleared. A new
// item is taken only once the previous result has been transferred out.
module circular_fifo_with_search_top
  import cfs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [DATA_W-1:0]   s_axis_tdata,  // data[31:0]
  input  logic [FUNC_W-1:0]   s_axis_tuser,  // func[1:0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OUT_W-1:0]    m_axis_tdata,  // value[31:0], slot[38:32], zero pad
  output logic [STATUS_W-1:0] m_axis_tuser   // status[1:0]
);

  cmd_t              cmd;
  sts_t              sts;
  logic [DATA_W-1:0] value;
  logic [SLOT_W-1:0] slot;

  // The controller sequences each operation; the datapath owns the ring
  // pointers, the storage RAM, the search scanner and the result register.
  cfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_func  (s_axis_tuser),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cfs_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_data    (s_axis_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_status (m_axis_tuser),
    .out_value  (value),
    .out_slot   (slot)
  );

  // Pack the result word; the unused top bits are held at zero.
  assign m_axis_tdata = {{(OUT_W - DATA_W - SLOT_W){1'b0}}, slot, value};

endmodule

// ----- dv/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cfs_pkg::*;

  // The clock toggles every 5 ns. The watchdog fires at TIMEOUT_NS, and a clean run needs
  // well under that, even with every search walking a full ring.
  localparam int TIMEOUT_NS  = 5_000_000;
  localparam int N_RANDOM    = 450;
  localparam int MAX_REPORTS = 10;

  // One stimulus item, as the driver presents it on the slave side.
  typedef struct packed {
    func_t             func;
    logic [DATA_W-1:0] data;
  } op_item_t;

  // One result item, as it is unpacked from the master side.
  typedef struct packed {
    status_t           status;
    logic [DATA_W-1:0] value;
    logic [SLOT_W-1:0] slot;
  } reply_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [DATA_W-1:0]   s_axis_tdata = '0;   // data[31:0]
  logic [FUNC_W-1:0]   s_axis_tuser = '0;   // func[1:0]
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_W-1:0]    m_axis_tdata;        // value[31:0], slot[38:32], zero pad
  logic [STATUS_W-1:0] m_axis_tuser;        // status[1:0]

  circular_fifo_with_search_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Items waiting to be offered, and the results predicted for items already taken in.
  op_item_t ops_to_send[$];
  reply_t   replies_due[$];
  op_item_t cur_op;

  int n_items;
  int n_accepted = 0;
  int n_checked = 0;
  int n_bad = 0;
  logic rx_hold = 1'b0;

  // This is the testbench's own picture of the ring. It is updated once per accepted transfer.
  logic [DATA_W-1:0] ring_mem [DEPTH];
  int ring_head = 0;
  int ring_tail = 0;
  int ring_count = 0;

  // The stimulus generator keeps a rough occupancy count, so that it can aim at full and empty.
  int gen_occ = 0;
  logic [DATA_W-1:0] word_pool [16];

  // Applies one operation to the ring picture and returns the result that the block owes for it.
  function automatic reply_t ring_apply(op_item_t op);
    reply_t r;
    int idx;
    bit hit;
    r = '{status: ST_DONE, value: '0, slot: '0};
    hit = 1'b0;
    case (op.func)
      FUNC_PUSH: begin
        if (ring_count == DEPTH) begin
          r.status = ST_OVERFLOW;
        end else begin
          ring_mem[ring_tail] = op.data;
          ring_tail = (ring_tail + 1) % DEPTH;
          ring_count++;
        end
      end
      FUNC_POP: begin
        if (ring_count == 0) begin
          r.status = ST_UNDERFLOW;
          r.value  = '1;
        end else begin
          r.value = ring_mem[ring_head];
          ring_head = (ring_head + 1) % DEPTH;
          ring_count--;
        end
      end
      FUNC_SEARCH: begin
        // The walk goes from the oldest entry to the newest, the newest included, and keeps
        // only the first match. It never looks at slots outside the occupied span.
        idx = ring_head;
        for (int n = 0; n < ring_count; n++) begin
          if (!hit && ring_mem[idx] == op.data) begin
            hit = 1'b1;
            r.slot = SLOT_W'(idx);
          end
          idx = (idx + 1) % DEPTH;
        end
        if (!hit) r.status = ST_NOTFOUND;
      end
      default: begin
        // The unused opcode leaves the ring alone and reports plain success.
      end
    endcase
    return r;
  endfunction

  // The idle rate depends on how far the run has got. For the first third the sender idles
  // 25% and the receiver 85%. For the second third the rates are swapped. For the last
  // third neither side idles.
  function automatic int idle_pct(bit sender_side, int done);
    if (done < n_items / 3) return sender_side ? 25 : 85;
    if (done < (2 * n_items) / 3) return sender_side ? 85 : 25;
    return 0;
  endfunction

  task automatic add_item(func_t f, logic [DATA_W-1:0] d);
    ops_to_send.push_back('{func: f, data: d});
    if (f == FUNC_PUSH && gen_occ < DEPTH) gen_occ++;
    if (f == FUNC_POP && gen_occ > 0) gen_occ--;
  endtask

  // Half the words come from a small pool, so that searches hit and duplicates appear.
  function automatic logic [DATA_W-1:0] pick_word();
    if ($urandom_range(0, 1) == 0) return word_pool[$urandom_range(0, 15)];
    return $urandom;
  endfunction

  // The driver offers the next queued item, barring a random idle, whenever the slave
  // side is free. A held item stays on the bus until its transfer completes. Each accepted
  // transfer is run through the ring picture at once: results leave in the order items arrive.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        replies_due.push_back(ring_apply(cur_op));
        n_accepted <= n_accepted + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (ops_to_send.size() != 0 &&
            $urandom_range(0, 99) >= idle_pct(1'b1, n_accepted)) begin
          cur_op = ops_to_send.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= cur_op.func;
          s_axis_tdata  <= cur_op.data;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // The monitor takes results off the master side and compares each one with the oldest
  // prediction. It also decides the ready level for the next cycle.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (replies_due.size() == 0) begin
          if (n_bad < MAX_REPORTS)
            $display("unexpected result: status %0d value %08h slot %0d",
                     m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[38:32]);
          n_bad <= n_bad + 1;
        end else begin
          reply_t exp_r;
          exp_r = replies_due.pop_front();
          if (m_axis_tuser !== exp_r.status || m_axis_tdata[31:0] !== exp_r.value ||
              m_axis_tdata[38:32] !== exp_r.slot) begin
            if (n_bad < MAX_REPORTS)
              $display("result %0d wrong: status %0d/%0d value %08h/%08h slot %0d/%0d",
                       n_checked, exp_r.status, m_axis_tuser, exp_r.value,
                       m_axis_tdata[31:0], exp_r.slot, m_axis_tdata[38:32]);
            n_bad <= n_bad + 1;
          end
        end
        n_checked <= n_checked + 1;
      end
      m_axis_tready <= !rx_hold && ($urandom_range(0, 99) >= idle_pct(1'b0, n_accepted));
    end
  end

  // At one point the receiver stops taking results for a long stretch. The sender keeps
  // offering items meanwhile, so the block has to stall its input with a result held.
  initial begin
    wait (n_accepted >= 60);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int kind;
    int len;
    bit filled;
    filled = 1'b0;
    for (int i = 0; i < 16; i++) word_pool[i] = $urandom;
    word_pool[0] = 32'h8000_0000;
    word_pool[1] = 32'h7FFF_FFFF;

    // The directed part starts with the empty queue. It covers the corner values, a
    // duplicate, a hit on the newest entry and a miss. It then drains to empty, and a
    // search of the stale words shows that they are no longer reachable.
    add_item(FUNC_POP, 32'h0);
    add_item(FUNC_SEARCH, 32'h0);
    add_item(FUNC_NOP, 32'hFFFF_FFFF);
    add_item(FUNC_PUSH, 32'h8000_0000);
    add_item(FUNC_PUSH, 32'h7FFF_FFFF);
    add_item(FUNC_PUSH, 32'h0000_0000);
    add_item(FUNC_PUSH, 32'hFFFF_FFFF);
    add_item(FUNC_PUSH, 32'h1234_5678);
    add_item(FUNC_PUSH, 32'h8000_0000);
    add_item(FUNC_PUSH, 32'h5A5A_5A5A);
    add_item(FUNC_SEARCH, 32'h8000_0000);
    add_item(FUNC_SEARCH, 32'h1234_5678);
    add_item(FUNC_SEARCH, 32'h5A5A_5A5A);
    add_item(FUNC_SEARCH, 32'h0000_0001);
    add_item(FUNC_NOP, 32'h0);
    add_item(FUNC_POP, 32'hFFFF_FFFF);
    add_item(FUNC_SEARCH, 32'h8000_0000);
    repeat (6) add_item(FUNC_POP, 32'h0);
    add_item(FUNC_POP, 32'h0);
    add_item(FUNC_SEARCH, 32'h5A5A_5A5A);

    // The random part is made of bursts. Pushes are favored so that the ring fills and
    // wraps. Once, the ring is driven all the way to full and then pushed past full.
    while (ops_to_send.size() < 25 + N_RANDOM) begin
      if (!filled && ops_to_send.size() > 150) begin
        repeat (DEPTH - gen_occ + 3) add_item(FUNC_PUSH, pick_word());
        add_item(FUNC_SEARCH, pick_word());
        add_item(FUNC_SEARCH, $urandom);
        filled = 1'b1;
      end
      kind = $urandom_range(0, 9);
      len  = $urandom_range(1, 20);
      if ($urandom_range(0, 7) == 0) word_pool[$urandom_range(2, 15)] = $urandom;
      case (kind)
        0, 1, 2, 3: repeat (len) add_item(FUNC_PUSH, pick_word());
        4, 5:       repeat (len) add_item(FUNC_POP, $urandom);
        6, 7: begin
          repeat (len) begin
            case ($urandom_range(0, 9))
              0, 1:    add_item(FUNC_PUSH, pick_word());
              2:       add_item(FUNC_POP, $urandom);
              default: add_item(FUNC_SEARCH, pick_word());
            endcase
          end
        end
        8: repeat (len / 3 + 1) add_item(func_t'($urandom_range(0, 3)), $urandom);
        default: begin
          // Draining past empty produces a run of underflows.
          repeat (gen_occ + 2) add_item(FUNC_POP, $urandom);
        end
      endcase
    end
    n_items = ops_to_send.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (n_accepted < n_items || replies_due.size() != 0) @(posedge clk);
    // A late search can take a full ring walk. Any result arriving in that window would be
    // reported as unexpected.
    repeat (DEPTH + 8) @(posedge clk);

    if (n_bad == 0 && replies_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/cfs_pkg.sv
hw/rtl/cfs_ctrl.sv
hw/rtl/cfs_dp.sv
hw/rtl/circular_fifo_with_search_top.sv
dv/testbench.sv
